### rtl/tlqg_pkg.sv
`default_nettype none
package tlqg_pkg;

	localparam int MAX_CHARS   = 1024;
	localparam int GLYPH_COUNT = 95;
	localparam int GLYPH_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int CNT_W       = 11;
	localparam int QDEPTH      = 4;
	localparam int QAW         = 2;
	localparam int QCW         = QAW + 1;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_CHAR = 2'd1;
	localparam logic [1:0] MODE_END  = 2'd2;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_CURSOR = 2'd1;
	localparam logic [1:0] KIND_BOUNDS = 2'd2;

	localparam logic [1:0] BODY_NONE   = 2'd0;
	localparam logic [1:0] BODY_GLYPH  = 2'd1;
	localparam logic [1:0] BODY_BOUNDS = 2'd2;

	localparam logic [1:0] REG_CURSOR_ENABLE = 2'd0;
	localparam logic [1:0] REG_CURSOR_INDEX  = 2'd1;
	localparam logic [1:0] REG_LINE_HEIGHT   = 2'd2;
	localparam logic [1:0] REG_EXTENT_TOP    = 2'd3;

	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd126;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SUBST   = 8'd63;

	localparam logic [CNT_W-1:0] MAX_CHARS_C = CNT_W'(MAX_CHARS);

	typedef struct packed {
		logic [11:0]        atlas_bottom;
		logic [11:0]        atlas_right;
		logic [11:0]        atlas_top;
		logic [11:0]        atlas_left;
		logic [13:0]        advance_fixed;
		logic [7:0]         glyph_height;
		logic [7:0]         glyph_width;
		logic signed [8:0]  offset_top;
		logic signed [8:0]  offset_left;
	} glyph_t;

	typedef struct packed {
		logic               has_cursor;
		logic [1:0]         body;
		logic signed [15:0] cur_x;
		logic signed [15:0] cur_y;
		logic [7:0]         cur_h;
		logic signed [15:0] x0;
		logic signed [15:0] y0;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic [11:0]        u0;
		logic [11:0]        v0;
		logic [11:0]        u1;
		logic [11:0]        v1;
		logic [14:0]        bw;
		logic [14:0]        bh;
	} cmd_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/tlqg_ram.sv
`default_nettype none
module tlqg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/tlqg_front.sv
`default_nettype none
module tlqg_front import tlqg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         mode,
	input  wire logic [7:0]         code_byte,
	input  wire logic signed [8:0]  offset_left,
	input  wire logic signed [8:0]  offset_top,
	input  wire logic [7:0]         glyph_width,
	input  wire logic [7:0]         glyph_height,
	input  wire logic [13:0]        advance_fixed,
	input  wire logic [11:0]        atlas_left,
	input  wire logic [11:0]        atlas_top,
	input  wire logic [11:0]        atlas_right,
	input  wire logic [11:0]        atlas_bottom,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [10:0]        cfg_wdata,
	input  wire logic [QCW-1:0]     q_count,
	output logic                    q_push,
	output cmd_t                    q_data
);

	logic               cursor_enable_q;
	logic [10:0]        cursor_index_q;
	logic [7:0]         line_height_q;
	logic signed [8:0]  extent_top_q;

	logic signed [15:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic [CNT_W-1:0]   char_count_q;
	logic signed [15:0] widest_x_q;
	logic signed [15:0] last_line_y_q;

	logic               valid_s1;
	logic               is_end_s1;
	logic               is_nl_s1;
	logic               ent_ok_s1;

	logic               accept;
	logic               load_ok;
	logic [7:0]         load_idx;
	logic [7:0]         draw_code;
	logic [7:0]         draw_idx;
	logic               draw_ok;
	logic               ram_we;
	glyph_t             wr_glyph;
	glyph_t             rd_glyph;
	glyph_t             g;

	logic signed [15:0] x0;
	logic signed [15:0] y0;
	logic signed [15:0] x1;
	logic signed [15:0] y1;
	logic signed [15:0] pen_x_nx;
	logic signed [15:0] pen_y_nl;
	logic signed [15:0] cur_y;
	logic signed [17:0] bh_sum;
	logic [14:0]        bh;
	logic [14:0]        bw;
	logic               capped;
	logic               cursor_hit;

	assign full   = ({1'b0, q_count} + {{QCW{1'b0}}, valid_s1}) >= (QCW+1)'(QDEPTH);
	assign accept = push && !full;

	always_comb begin
		load_ok   = (code_byte >= CODE_FIRST) && (code_byte <= CODE_LAST);
		load_idx  = code_byte - CODE_FIRST;
		draw_code = load_ok ? code_byte : CODE_SUBST;
		draw_idx  = draw_code - CODE_FIRST;
		draw_ok   = {1'b0, draw_idx} < 9'(GLYPH_COUNT);
		ram_we    = accept && (mode == MODE_LOAD) && load_ok &&
		            ({1'b0, load_idx} < 9'(GLYPH_COUNT));
		wr_glyph.atlas_bottom  = atlas_bottom;
		wr_glyph.atlas_right   = atlas_right;
		wr_glyph.atlas_top     = atlas_top;
		wr_glyph.atlas_left    = atlas_left;
		wr_glyph.advance_fixed = advance_fixed;
		wr_glyph.glyph_height  = glyph_height;
		wr_glyph.glyph_width   = glyph_width;
		wr_glyph.offset_top    = offset_top;
		wr_glyph.offset_left   = offset_left;
	end

	tlqg_ram #(
		.WIDTH ($bits(glyph_t)),
		.DEPTH (GLYPH_COUNT)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_idx[GLYPH_AW-1:0]),
		.wdata (wr_glyph),
		.re    (accept),
		.raddr (draw_idx[GLYPH_AW-1:0]),
		.rdata (rd_glyph)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			is_end_s1 <= 1'b0;
			is_nl_s1  <= 1'b0;
			ent_ok_s1 <= 1'b0;
		end else begin
			valid_s1  <= accept && ((mode == MODE_CHAR) || (mode == MODE_END));
			is_end_s1 <= mode == MODE_END;
			is_nl_s1  <= code_byte == CODE_NEWLINE;
			ent_ok_s1 <= draw_ok;
		end
	end

	always_comb begin
		g          = ent_ok_s1 ? rd_glyph : '0;
		x0         = sat16(18'(pen_x_q) + 18'(g.offset_left));
		y0         = sat16(18'(pen_y_q) - 18'(g.offset_top));
		x1         = sat16(18'(x0) + $signed({10'd0, g.glyph_width}));
		y1         = sat16(18'(y0) + $signed({10'd0, g.glyph_height}));
		pen_x_nx   = sat16(18'(pen_x_q) + $signed({10'd0, g.advance_fixed[13:6]}));
		pen_y_nl   = sat16(18'(pen_y_q) + $signed({10'd0, line_height_q}));
		cur_y      = sat16(18'(pen_y_q) + 18'(extent_top_q));
		bh_sum     = 18'(last_line_y_q) + $signed({10'd0, line_height_q});
		if (bh_sum > 18'sd32767) begin
			bh = 15'h7fff;
		end else if (bh_sum < 18'sd0) begin
			bh = 15'd0;
		end else begin
			bh = bh_sum[14:0];
		end
		bw         = widest_x_q[15] ? 15'd0 : widest_x_q[14:0];
		capped     = !is_end_s1 && (char_count_q >= MAX_CHARS_C);
		cursor_hit = cursor_enable_q && (char_count_q == cursor_index_q);

		q_data.has_cursor = cursor_hit;
		q_data.cur_x      = pen_x_q;
		q_data.cur_y      = cur_y;
		q_data.cur_h      = line_height_q;
		q_data.x0         = x0;
		q_data.y0         = y0;
		q_data.x1         = x1;
		q_data.y1         = y1;
		q_data.u0         = g.atlas_left;
		q_data.v0         = g.atlas_top;
		q_data.u1         = g.atlas_right;
		q_data.v1         = g.atlas_bottom;
		q_data.bw         = bw;
		q_data.bh         = bh;
		q_push            = 1'b0;
		q_data.body       = BODY_NONE;
		if (valid_s1 && !capped) begin
			if (is_end_s1) begin
				q_data.body = BODY_BOUNDS;
				q_data.y0   = -16'(extent_top_q);
				q_push      = 1'b1;
			end else if (is_nl_s1) begin
				q_push = cursor_hit;
			end else begin
				q_data.body = BODY_GLYPH;
				q_push      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_enable_q <= 1'b0;
			cursor_index_q  <= 11'd0;
			line_height_q   <= 8'd16;
			extent_top_q    <= 9'sd0;
		end else if (cfg_write) begin
			case (cfg_addr)
				REG_CURSOR_ENABLE: cursor_enable_q <= cfg_wdata[0];
				REG_CURSOR_INDEX:  cursor_index_q  <= cfg_wdata;
				REG_LINE_HEIGHT:   line_height_q   <= cfg_wdata[7:0];
				REG_EXTENT_TOP:    extent_top_q    <= cfg_wdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q       <= '0;
			pen_y_q       <= '0;
			char_count_q  <= '0;
			widest_x_q    <= '0;
			last_line_y_q <= '0;
		end else if (valid_s1 && !capped) begin
			if (is_end_s1) begin
				pen_x_q       <= '0;
				pen_y_q       <= '0;
				char_count_q  <= '0;
				widest_x_q    <= '0;
				last_line_y_q <= '0;
			end else begin
				char_count_q <= char_count_q + CNT_W'(1);
				if (is_nl_s1) begin
					pen_x_q       <= '0;
					pen_y_q       <= pen_y_nl;
					last_line_y_q <= pen_y_nl;
				end else begin
					pen_x_q <= pen_x_nx;
					if (pen_x_nx > widest_x_q) begin
						widest_x_q <= pen_x_nx;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/tlqg_cmd_fifo.sv
`default_nettype none
module tlqg_cmd_fifo import tlqg_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire cmd_t           wdata,
	input  wire logic           rd,
	output cmd_t                rdata,
	output logic                not_empty,
	output logic [QCW-1:0]      count
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign rdata     = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + QCW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/tlqg_back.sv
`default_nettype none
module tlqg_back import tlqg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic               cmd_valid,
	output logic                    cmd_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              kind,
	output logic signed [15:0]      pos_x,
	output logic signed [15:0]      pos_y,
	output logic [11:0]             tex_u,
	output logic [11:0]             tex_v,
	output logic [14:0]             box_w,
	output logic [14:0]             box_h,
	output logic                    last
);

	logic               out_valid_q;
	logic [2:0]         step_q;
	logic               advance;
	logic [2:0]         n_res;
	logic [2:0]         j;
	logic               xsel;
	logic               ysel;
	logic               is_last;
	logic [1:0]         r_kind;
	logic signed [15:0] r_x;
	logic signed [15:0] r_y;
	logic [11:0]        r_u;
	logic [11:0]        r_v;
	logic [14:0]        r_w;
	logic [14:0]        r_h;

	assign empty   = !out_valid_q;
	assign advance = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = advance && is_last;

	always_comb begin
		n_res = {2'd0, cmd.has_cursor};
		if (cmd.body == BODY_GLYPH) begin
			n_res = n_res + 3'd6;
		end else if (cmd.body == BODY_BOUNDS) begin
			n_res = n_res + 3'd1;
		end
		is_last = step_q == (n_res - 3'd1);
		j       = step_q - {2'd0, cmd.has_cursor};
		xsel    = j inside {3'd2, 3'd3, 3'd5};
		ysel    = j inside {3'd1, 3'd4, 3'd5};
		r_kind  = KIND_VERTEX;
		r_x     = xsel ? cmd.x1 : cmd.x0;
		r_y     = ysel ? cmd.y1 : cmd.y0;
		r_u     = xsel ? cmd.u1 : cmd.u0;
		r_v     = ysel ? cmd.v1 : cmd.v0;
		r_w     = '0;
		r_h     = '0;
		if (cmd.has_cursor && (step_q == 3'd0)) begin
			r_kind = KIND_CURSOR;
			r_x    = cmd.cur_x;
			r_y    = cmd.cur_y;
			r_u    = '0;
			r_v    = '0;
			r_w    = 15'd1;
			r_h    = {7'd0, cmd.cur_h};
		end else if (cmd.body == BODY_BOUNDS) begin
			r_kind = KIND_BOUNDS;
			r_x    = '0;
			r_y    = cmd.y0;
			r_u    = '0;
			r_v    = '0;
			r_w    = cmd.bw;
			r_h    = cmd.bh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? 3'd0 : step_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind  <= r_kind;
			pos_x <= r_x;
			pos_y <= r_y;
			tex_u <= r_u;
			tex_v <= r_v;
			box_w <= r_w;
			box_h <= r_h;
			last  <= is_last;
		end
	end

endmodule
`default_nettype wire

### rtl/text_layout_quad_generator.sv
// a request's first result reaches the result ports via the front's stage-1 registers,
// the command queue and the back end's output registers; the back end gives one result
// per cycle while pop keeps up, six per drawn glyph (seven with a cursor box); loads and
// results-free requests queue nothing; the front takes a request every cycle while the
// four-entry command queue has room; reset: async active low; clears pen, counters, queue
// and registers to defaults; the glyph table is not cleared and must be loaded before use
`default_nettype none
module text_layout_quad_generator import tlqg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         mode,
	input  wire logic [7:0]         code_byte,
	input  wire logic signed [8:0]  offset_left,
	input  wire logic signed [8:0]  offset_top,
	input  wire logic [7:0]         glyph_width,
	input  wire logic [7:0]         glyph_height,
	input  wire logic [13:0]        advance_fixed,
	input  wire logic [11:0]        atlas_left,
	input  wire logic [11:0]        atlas_top,
	input  wire logic [11:0]        atlas_right,
	input  wire logic [11:0]        atlas_bottom,
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              kind,
	output logic signed [15:0]      pos_x,
	output logic signed [15:0]      pos_y,
	output logic [11:0]             tex_u,
	output logic [11:0]             tex_v,
	output logic [14:0]             box_w,
	output logic [14:0]             box_h,
	output logic                    last,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [10:0]        cfg_wdata
);

	cmd_t           q_wdata;
	cmd_t           q_rdata;
	logic           q_push;
	logic           q_pop;
	logic           q_not_empty;
	logic [QCW-1:0] q_count;

	tlqg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.code_byte     (code_byte),
		.offset_left   (offset_left),
		.offset_top    (offset_top),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.advance_fixed (advance_fixed),
		.atlas_left    (atlas_left),
		.atlas_top     (atlas_top),
		.atlas_right   (atlas_right),
		.atlas_bottom  (atlas_bottom),
		.cfg_write     (cfg_write),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.q_count       (q_count),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	tlqg_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_push),
		.wdata     (q_wdata),
		.rd        (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	tlqg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_rdata),
		.cmd_valid (q_not_empty),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.box_w     (box_w),
		.box_h     (box_h),
		.last      (last)
	);

endmodule
`default_nettype wire
